/* rtl/tslsp_pkg.sv */
// ----------------------------------------------------------------------------
// tslsp_pkg
// shared constants, register indexes and control types for the loop player
// ----------------------------------------------------------------------------
package tslsp_pkg;

    // default parameter values
    localparam int STORE_DEPTH_DEF   = 65536;
    localparam int FRACTION_BITS_DEF = 16;

    // field widths
    localparam int SAMPLE_W   = 16;
    localparam int MIX_W      = 24;
    localparam int BAR_W      = 5;
    localparam int IN_DATA_W  = 88;
    localparam int IN_USER_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // shared multiply-accumulate unit
    localparam int MUL_W = 26;
    localparam int ACC_W = 64;
    localparam int LO_W  = 25;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLIP_END      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAR_COUNT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_REVERSE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN          = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STORED_LENGTH = 3'd7;

    // control of the shared multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic clear;
        logic shift_hi;
    } mac_ctl_t;

endpackage

/* rtl/tslsp_store.sv */
// ----------------------------------------------------------------------------
// tslsp_store
// sample memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module tslsp_store #(
    parameter int DEPTH = tslsp_pkg::STORE_DEPTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [$clog2(DEPTH)-1:0]              waddr,
    input  logic signed [tslsp_pkg::SAMPLE_W-1:0] wdata,
    input  logic [$clog2(DEPTH)-1:0]              raddr,
    output logic signed [tslsp_pkg::SAMPLE_W-1:0] rdata
);
    import tslsp_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/tslsp_mac.sv */
// ----------------------------------------------------------------------------
// tslsp_mac
// shared signed multiply-accumulate unit, one product per enabled cycle
// ----------------------------------------------------------------------------
module tslsp_mac (
    input  logic                               clk,
    input  tslsp_pkg::mac_ctl_t                ctl,
    input  logic signed [tslsp_pkg::MUL_W-1:0] a,
    input  logic signed [tslsp_pkg::MUL_W-1:0] b,
    output logic signed [tslsp_pkg::ACC_W-1:0] acc
);
    import tslsp_pkg::*;

    logic signed [2*MUL_W-1:0] prod;
    logic signed [ACC_W-1:0]   prod_x;
    logic signed [ACC_W-1:0]   addend;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [ACC_W-1:0]   acc_next;

    assign prod   = a * b;
    assign prod_x = ACC_W'(prod);
    // upper partial product of a wide operand lands LO_W bits higher
    assign addend = ctl.shift_hi ? (prod_x <<< LO_W) : prod_x;

    always_comb
    begin
        if (ctl.clear)
        begin
            acc_next = addend;
        end
        else
        begin
            acc_next = acc_reg + addend;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

/* rtl/tslsp_div.sv */
// ----------------------------------------------------------------------------
// tslsp_div
// restoring divider by a bar count, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tslsp_div #(
    parameter int N = 38
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [N-1:0]                    dividend,
    input  logic [tslsp_pkg::BAR_W-1:0]     divisor,
    output logic                            done,
    output logic [N-1:0]                    quotient,
    output logic [tslsp_pkg::BAR_W-1:0]     remainder
);
    import tslsp_pkg::*;

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]       quo_reg;
    logic [BAR_W-1:0]   rem_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [BAR_W:0]     rem_sh;
    logic [BAR_W:0]     rem_sub;
    logic               fits;

    assign rem_sh  = {rem_reg, quo_reg[N-1]};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign fits    = rem_sh >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(N);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[N-2:0], fits};
            rem_reg <= fits ? rem_sub[BAR_W-1:0] : rem_sh[BAR_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/tempo_synced_loop_sample_player.sv */
// ----------------------------------------------------------------------------
// tempo_synced_loop_sample_player
// loop sample voice locked to the transport, interpolated and mixed in
// ----------------------------------------------------------------------------
// items arrive on the s_axis channel; tuser[0] picks load (0) or render (1)
// a load writes one sample to the store and is done in its transfer cycle,
// tready stays high so loads stream one per cycle
// a render runs on one shared multiply-accumulate unit under a sequencer;
// tready returns after its final step, which writes the result into the
// output register
// a render with first_of_block also runs the serial divider twice (measure
// modulo bar count, then scaling to the clip)
// the output register holds one result; the next item is taken while it waits,
// and a render stalls at its final step only if that register is still full
// the user must write the configuration port only while the block is idle,
// which the block does not enforce; reset clears the playhead and loads the
// register defaults; the sample store is not cleared or meaningful until loaded
// ----------------------------------------------------------------------------
module tempo_synced_loop_sample_player #(
    parameter int STORE_DEPTH   = tslsp_pkg::STORE_DEPTH_DEF,
    parameter int FRACTION_BITS = tslsp_pkg::FRACTION_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [tslsp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tslsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // load_address, load_value, measure_fraction, measure_number, mix_in
    input  logic [tslsp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // action, first_of_block
    input  logic [tslsp_pkg::IN_USER_W-1:0]     s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // mix_out
    output logic [tslsp_pkg::MIX_W-1:0]         m_axis_tdata
);
    import tslsp_pkg::*;

    localparam int PH_W   = FRACTION_BITS + 18;
    localparam int UP     = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
    localparam int DN     = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
    localparam int MAG_W  = 38;
    localparam int DIV_W  = MAG_W + UP;
    localparam int STEP_W = 24 + UP;
    localparam int SH     = FRACTION_BITS + 6;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_MOD_GO    = 4'd1;
    localparam logic [3:0] S_MOD_WAIT  = 4'd2;
    localparam logic [3:0] S_PMUL      = 4'd3;
    localparam logic [3:0] S_PDIV_GO   = 4'd4;
    localparam logic [3:0] S_PDIV_WAIT = 4'd5;
    localparam logic [3:0] S_PSET      = 4'd6;
    localparam logic [3:0] S_WRAP_HI   = 4'd7;
    localparam logic [3:0] S_WRAP_LO   = 4'd8;
    localparam logic [3:0] S_CHECK     = 4'd9;
    localparam logic [3:0] S_VSQ       = 4'd10;
    localparam logic [3:0] S_V0        = 4'd11;
    localparam logic [3:0] S_V1        = 4'd12;
    localparam logic [3:0] S_VL        = 4'd13;
    localparam logic [3:0] S_VH        = 4'd14;
    localparam logic [3:0] S_FIN       = 4'd15;

    // configuration
    logic [15:0]            clip_start_reg;
    logic [16:0]            clip_end_reg;
    logic [BAR_W-1:0]       bar_count_reg;
    logic signed [15:0]     start_offset_reg;
    logic                   play_reverse_reg;
    logic [15:0]            gain_reg;
    logic [23:0]            phase_step_reg;
    logic [16:0]            stored_length_reg;

    // sequencer and item state
    logic [3:0]             state_reg;
    logic [3:0]             state_next;
    logic signed [PH_W-1:0] ph_reg;
    logic signed [PH_W-1:0] ph_next;
    logic [15:0]            measure_fraction_reg;
    logic [15:0]            measure_number_reg;
    logic signed [MIX_W-1:0] mix_in_reg;
    logic                   neg_reg;
    logic                   past_reg;
    logic                   rd_ok_reg;
    logic signed [SAMPLE_W-1:0] s0_reg;
    logic signed [SAMPLE_W-1:0] s1_reg;
    logic [18:0]            vsq_reg;
    logic signed [MUL_W-1:0] v_hi_reg;
    logic [MIX_W-1:0]       out_reg;
    logic                   m_valid_reg;

    // input fields
    logic                   in_xfer;
    logic [15:0]            load_address;
    logic signed [15:0]     load_value;
    logic [15:0]            measure_fraction;
    logic [15:0]            measure_number;
    logic signed [MIX_W-1:0] mix_in;

    assign load_address     = s_axis_tdata[15:0];
    assign load_value       = s_axis_tdata[31:16];
    assign measure_fraction = s_axis_tdata[47:32];
    assign measure_number   = s_axis_tdata[63:48];
    assign mix_in           = s_axis_tdata[87:64];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // loop region in playhead units
    logic signed [17:0]     len;
    logic signed [17:0]     ofs;
    logic signed [PH_W-1:0] len_f;
    logic signed [PH_W-1:0] end_f;
    logic signed [PH_W-1:0] start_f;
    logic signed [PH_W-1:0] base_f;

    assign len     = $signed({1'b0, clip_end_reg}) - $signed({2'b00, clip_start_reg});
    assign ofs     = $signed({2'b00, clip_start_reg}) + 18'(start_offset_reg);
    assign len_f   = {len, {FRACTION_BITS{1'b0}}};
    assign end_f   = {1'b0, clip_end_reg, {FRACTION_BITS{1'b0}}};
    assign start_f = {2'b00, clip_start_reg, {FRACTION_BITS{1'b0}}};
    assign base_f  = {ofs, {FRACTION_BITS{1'b0}}};

    // serial divider
    logic [BAR_W-1:0]       bc;
    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic                   div_done;
    logic [DIV_W-1:0]       div_quo;
    logic [BAR_W-1:0]       div_rem;

    assign bc = (bar_count_reg == '0) ? BAR_W'(1) : bar_count_reg;

    // shared multiply-accumulate
    mac_ctl_t               mac_ctl;
    logic signed [MUL_W-1:0] mul_a;
    logic signed [MUL_W-1:0] mul_b;
    logic signed [ACC_W-1:0] mac_acc;

    // block start position
    logic [20:0]            p_u;
    logic signed [22:0]     p_s;
    logic [ACC_W-1:0]       acc_abs;
    logic [DIV_W-1:0]       magf;
    logic signed [PH_W-1:0] q_ph;
    logic signed [PH_W-1:0] ph_start;

    assign p_u      = {div_rem, measure_fraction_reg};
    assign p_s      = play_reverse_reg ? (23'sd65536 - $signed({2'b00, p_u}))
                                       : $signed({2'b00, p_u});
    assign acc_abs  = mac_acc[ACC_W-1] ? -mac_acc : mac_acc;
    assign magf     = (DIV_W'(acc_abs[MAG_W-1:0]) << UP) >> DN;
    assign div_dividend = (state_reg == S_MOD_GO) ? DIV_W'(measure_number_reg) : magf;
    assign div_start    = (state_reg == S_MOD_GO) || (state_reg == S_PDIV_GO);
    assign q_ph     = PH_W'(div_quo);
    assign ph_start = (neg_reg ? -q_ph : q_ph) + base_f;

    // read position
    logic signed [17:0]         pos;
    logic [FRACTION_BITS-1:0]   frac;
    logic [FRACTION_BITS:0]     one_minus;
    logic                       past;
    logic signed [18:0]         rd_idx;
    logic                       rd_ok;
    logic [ADDR_W-1:0]          rd_addr;
    logic signed [SAMPLE_W-1:0] st_rdata;
    logic                       st_we;

    assign pos       = ph_reg[PH_W-1:FRACTION_BITS];
    assign frac      = ph_reg[FRACTION_BITS-1:0];
    assign one_minus = {1'b1, {FRACTION_BITS{1'b0}}} - {1'b0, frac};
    assign past      = $signed({pos[17], pos}) >= $signed({2'b00, stored_length_reg});
    assign rd_idx    = (state_reg == S_VSQ) ? ($signed({pos[17], pos}) + 19'sd1)
                                            : $signed({pos[17], pos});
    // neighbours outside the valid samples read as zero
    assign rd_ok     = !rd_idx[18]
                       && (rd_idx[17:0] < {1'b0, stored_length_reg})
                       && (32'(rd_idx[17:0]) < STORE_DEPTH);
    assign rd_addr   = ADDR_W'(rd_idx[17:0]);
    assign st_we     = in_xfer && !s_axis_tuser[0] && (32'(load_address) < STORE_DEPTH);

    // playhead advance
    logic [STEP_W-1:0]      step_u;
    logic signed [PH_W-1:0] step_ph;
    logic signed [PH_W-1:0] ph_adv;

    assign step_u  = (STEP_W'(phase_step_reg) << UP) >> DN;
    assign step_ph = PH_W'(step_u);
    assign ph_adv  = play_reverse_reg ? (ph_reg - step_ph) : (ph_reg + step_ph);

    // result
    logic signed [ACC_W-1:0] rnd;
    logic signed [31:0]      contrib;
    logic signed [32:0]      sum;
    logic [MIX_W-1:0]        sat;
    logic                    out_free;
    logic                    fin_write;

    assign rnd     = mac_acc + $signed(ACC_W'(1) << (SH - 1));
    assign contrib = 32'(rnd >>> SH);
    assign sum     = 33'(mix_in_reg) + 33'(contrib);

    always_comb
    begin
        if (sum > 33'sd8388607)
        begin
            sat = 24'h7FFFFF;
        end
        else if (sum < -33'sd8388608)
        begin
            sat = 24'h800000;
        end
        else
        begin
            sat = sum[MIX_W-1:0];
        end
    end

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign fin_write = (state_reg == S_FIN) && out_free;

    tslsp_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (ADDR_W'(load_address)),
        .wdata (load_value),
        .raddr (rd_addr),
        .rdata (st_rdata)
    );

    tslsp_div #(
        .N (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (bc),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    tslsp_mac u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (mul_a),
        .b   (mul_b),
        .acc (mac_acc)
    );

    // operand selection for the shared unit
    always_comb
    begin
        mac_ctl = '0;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_PMUL:
            begin
                mac_ctl = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
                mul_a   = MUL_W'(p_s);
                mul_b   = MUL_W'(len);
            end
            S_VSQ:
            begin
                mac_ctl = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
                mul_a   = $signed(MUL_W'(gain_reg));
                mul_b   = $signed(MUL_W'(gain_reg));
            end
            S_V0:
            begin
                mac_ctl = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
                mul_a   = MUL_W'(s0_reg);
                mul_b   = $signed(MUL_W'(one_minus));
            end
            S_V1:
            begin
                mac_ctl = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b0};
                mul_a   = MUL_W'(s1_reg);
                mul_b   = $signed(MUL_W'(frac));
            end
            S_VL:
            begin
                // low part of the interpolated value times volume squared
                mac_ctl = '{en: 1'b1, clear: 1'b1, shift_hi: 1'b0};
                mul_a   = $signed(MUL_W'(mac_acc[LO_W-1:0]));
                mul_b   = $signed(MUL_W'(vsq_reg));
            end
            S_VH:
            begin
                mac_ctl = '{en: 1'b1, clear: 1'b0, shift_hi: 1'b1};
                mul_a   = v_hi_reg;
                mul_b   = $signed(MUL_W'(vsq_reg));
            end
            default:
            begin
                mac_ctl = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer && s_axis_tuser[0])
                begin
                    state_next = s_axis_tuser[1] ? S_MOD_GO : S_WRAP_HI;
                end
            end
            S_MOD_GO:    state_next = S_MOD_WAIT;
            S_MOD_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_PMUL;
                end
            end
            S_PMUL:      state_next = S_PDIV_GO;
            S_PDIV_GO:   state_next = S_PDIV_WAIT;
            S_PDIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_PSET;
                end
            end
            S_PSET:      state_next = S_WRAP_HI;
            S_WRAP_HI:   state_next = S_WRAP_LO;
            S_WRAP_LO:   state_next = S_CHECK;
            S_CHECK:     state_next = past ? S_FIN : S_VSQ;
            S_VSQ:       state_next = S_V0;
            S_V0:        state_next = S_V1;
            S_V1:        state_next = S_VL;
            S_VL:        state_next = S_VH;
            S_VH:        state_next = S_FIN;
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // playhead: block start, single wrap each way, then advance
    always_comb
    begin
        ph_next = ph_reg;
        case (state_reg)
            S_PSET:    ph_next = ph_start;
            S_WRAP_HI:
            begin
                if (ph_reg >= end_f)
                begin
                    ph_next = ph_reg - len_f;
                end
            end
            S_WRAP_LO:
            begin
                if (ph_reg < start_f)
                begin
                    ph_next = ph_reg + len_f;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ph_next = ph_adv;
                end
            end
            default:   ph_next = ph_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ph_reg      <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            if (fin_write)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_start_reg    <= 16'd0;
            clip_end_reg      <= 17'd65536;
            bar_count_reg     <= BAR_W'(1);
            start_offset_reg  <= 16'sd0;
            play_reverse_reg  <= 1'b0;
            gain_reg          <= 16'd16384;
            phase_step_reg    <= 24'd65536;
            stored_length_reg <= 17'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CLIP_START:    clip_start_reg    <= cfg_data[15:0];
                REG_CLIP_END:      clip_end_reg      <= cfg_data[16:0];
                REG_BAR_COUNT:     bar_count_reg     <= cfg_data[BAR_W-1:0];
                REG_START_OFFSET:  start_offset_reg  <= cfg_data[15:0];
                REG_PLAY_REVERSE:  play_reverse_reg  <= cfg_data[0];
                REG_GAIN:          gain_reg          <= cfg_data[15:0];
                REG_PHASE_STEP:    phase_step_reg    <= cfg_data[23:0];
                REG_STORED_LENGTH: stored_length_reg <= cfg_data[16:0];
                default:           ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            measure_fraction_reg <= measure_fraction;
            measure_number_reg   <= measure_number;
            mix_in_reg           <= mix_in;
        end
        rd_ok_reg <= rd_ok;
        if (state_reg == S_PDIV_GO)
        begin
            neg_reg <= mac_acc[ACC_W-1];
        end
        if (state_reg == S_CHECK)
        begin
            past_reg <= past;
        end
        if (state_reg == S_VSQ)
        begin
            s0_reg <= rd_ok_reg ? st_rdata : '0;
        end
        if (state_reg == S_V0)
        begin
            s1_reg  <= rd_ok_reg ? st_rdata : '0;
            // rounded volume squared, Q.14
            vsq_reg <= 19'(({1'b0, mac_acc[31:0]} + 33'd8192) >> 14);
        end
        if (state_reg == S_VL)
        begin
            v_hi_reg <= MUL_W'(mac_acc >>> LO_W);
        end
        if (fin_write)
        begin
            out_reg <= past_reg ? '0 : sat;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

endmodule
